>>> design/piecewise_linear_transfer_table_defines.svh
// assertion macros shared by the piecewise linear transfer table rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef PIECEWISE_LINEAR_TRANSFER_TABLE_DEFINES_SVH
`define PIECEWISE_LINEAR_TRANSFER_TABLE_DEFINES_SVH

// property that holds at every clock edge outside reset
`define PLT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("plt assertion failed");

// consequence in the cycle after the trigger
`define PLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plt assertion failed");

`endif

>>> design/plt_pkg.sv
// types, codes and constants of the piecewise linear transfer table
// used by every module of the block except plt_ram, no dependencies
package plt_pkg;

  localparam int unsigned PLT_MAX_POINTS = 64;
  localparam int unsigned PLT_PROD_W     = 50;
  localparam int unsigned PLT_DEN_W      = 16;

  localparam logic [1:0] CMD_MAP    = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] level;
    logic signed [31:0] point_value;
    logic [5:0]         position;
  } plt_in_t;

  typedef struct packed {
    logic signed [31:0] mapped;
    logic [6:0]         points_held;
    logic [1:0]         status;
  } plt_out_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic signed [31:0] value;
  } plt_entry_t;

  typedef enum logic [2:0] {K_HOLD, K_ZERO, K_COUNT, K_POS, K_INC, K_DEC} k_op_e;
  typedef enum logic [1:0] {RD_K, RD_KM1, RD_KP1} rd_off_e;
  typedef enum logic [1:0] {WR_NONE, WR_RDATA, WR_NEW} wr_sel_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_e;
  typedef enum logic [1:0] {RES_ZERO, RES_RDATA, RES_INTERP} res_sel_e;

  typedef struct packed {
    logic       capture;
    k_op_e      k_op;
    rd_off_e    rd_off;
    wr_sel_e    wr_sel;
    cnt_op_e    cnt_op;
    logic       prev_ld;
    logic       cur_ld;
    logic       mul_en;
    logic       div_start;
    logic       finish;
    res_sel_e   res_sel;
    logic [1:0] stat;
    logic       out_load;
  } plt_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       cnt_zero;
    logic       full;
    logic       pos_bad;
    logic       k_zero;
    logic       k_last;
    logic       s_lt_x;
    logic       s_eq_x;
    logic       x_gt_s;
    logic       div_busy;
    logic       out_free;
  } plt_sts_t;

endpackage

>>> design/plt_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module plt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/plt_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on plt_pkg for operand widths
module plt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [plt_pkg::PLT_PROD_W-1:0]  dividend_i,
  input  logic [plt_pkg::PLT_DEN_W-1:0]   divisor_i,
  output logic                            busy_o,
  output logic [plt_pkg::PLT_PROD_W-1:0]  quotient_o
);
  import plt_pkg::*;

  localparam int unsigned CntW = $clog2(PLT_PROD_W + 1);

  logic [PLT_PROD_W-1:0] acc_q;
  logic [PLT_DEN_W:0]    rem_q;
  logic [PLT_DEN_W-1:0]  div_q;
  logic [CntW-1:0]       cnt_q;
  logic [PLT_DEN_W:0]    trial;
  logic                  ge;

  assign trial = {rem_q[PLT_DEN_W-1:0], acc_q[PLT_PROD_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(PLT_PROD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? (trial - {1'b0, div_q}) : trial;
      acc_q <= {acc_q[PLT_PROD_W-2:0], ge};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = acc_q;

endmodule

>>> design/plt_dp.sv
// datapath: point table ram, counters, interpolation multiply and divide,
// result and output registers; depends on plt_pkg, plt_ram, plt_div
`include "piecewise_linear_transfer_table_defines.svh"
module plt_dp #(
  parameter int unsigned MAX_POINTS = plt_pkg::PLT_MAX_POINTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plt_pkg::plt_in_t  in_i,
  output plt_pkg::plt_out_t out_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  plt_pkg::plt_cmd_t cmd_i,
  output plt_pkg::plt_sts_t sts_o
);
  import plt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  plt_in_t    item_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] raddr_full;
  plt_entry_t prev_q, cur_q, rdata, wdata;
  logic       we;
  logic signed [32:0] dv;
  logic signed [16:0] dx, den;
  logic signed [PLT_PROD_W-1:0] prod_q;
  logic [PLT_DEN_W-1:0] den_q;
  logic [PLT_PROD_W-1:0] prod_mag, quot;
  logic        div_busy;
  logic [31:0] q32, interp, res_d;
  logic [31:0] res_q;
  logic [1:0]  stat_q;
  plt_out_t    out_q;
  logic        out_valid_q;

  always_comb begin
    unique case (cmd_i.k_op)
      K_HOLD:  k_d = k_q;
      K_ZERO:  k_d = '0;
      K_COUNT: k_d = cnt_q;
      K_POS:   k_d = CW'(item_q.position);
      K_INC:   k_d = k_q + 1'b1;
      K_DEC:   k_d = k_q - 1'b1;
      default: k_d = k_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_off)
      RD_K:    raddr_full = k_d;
      RD_KM1:  raddr_full = k_d - 1'b1;
      RD_KP1:  raddr_full = k_d + 1'b1;
      default: raddr_full = k_d;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + 1'b1;
      CNT_DEC:  cnt_d = cnt_q - 1'b1;
      CNT_CLR:  cnt_d = '0;
      default:  cnt_d = cnt_q;
    endcase
  end

  assign we    = cmd_i.wr_sel != WR_NONE;
  assign wdata = (cmd_i.wr_sel == WR_NEW) ? plt_entry_t'({item_q.level, item_q.point_value})
                                          : rdata;

  plt_ram #(
    .Width($bits(plt_entry_t)),
    .Depth(MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(k_q[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr_full[AW-1:0]),
    .rdata_o(rdata)
  );

  // interpolation terms
  assign dv  = 33'(cur_q.value) - 33'(prev_q.value);
  assign dx  = 17'(item_q.level) - 17'(prev_q.level);
  assign den = 17'(cur_q.level) - 17'(prev_q.level);
  assign prod_mag = prod_q[PLT_PROD_W-1] ? PLT_PROD_W'(-prod_q) : PLT_PROD_W'(prod_q);

  plt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(prod_mag),
    .divisor_i (den_q),
    .busy_o    (div_busy),
    .quotient_o(quot)
  );

  assign q32    = quot[31:0];
  assign interp = prev_q.value + (prod_q[PLT_PROD_W-1] ? (32'd0 - q32) : q32);

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_ZERO:   res_d = '0;
      RES_RDATA:  res_d = rdata.value;
      RES_INTERP: res_d = interp;
      default:    res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      k_q   <= k_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
    if (cmd_i.prev_ld) begin
      prev_q <= rdata;
    end
    if (cmd_i.cur_ld) begin
      cur_q <= rdata;
    end
    if (cmd_i.mul_en) begin
      prod_q <= dv * dx;
      den_q  <= den[PLT_DEN_W-1:0];
    end
    if (cmd_i.finish) begin
      res_q  <= res_d;
      stat_q <= cmd_i.stat;
    end
    if (cmd_i.out_load) begin
      out_q.mapped      <= res_q;
      out_q.points_held <= 7'(cnt_q);
      out_q.status      <= stat_q;
    end
  end

  always_comb begin
    sts_o.cmd      = item_q.cmd;
    sts_o.cnt_zero = cnt_q == '0;
    sts_o.full     = cnt_q >= CW'(MAX_POINTS);
    sts_o.pos_bad  = 32'(item_q.position) >= 32'(cnt_q);
    sts_o.k_zero   = k_q == '0;
    sts_o.k_last   = ({1'b0, k_q} + 1'b1) >= {1'b0, cnt_q};
    sts_o.s_lt_x   = item_q.level < rdata.level;
    sts_o.s_eq_x   = item_q.level == rdata.level;
    sts_o.x_gt_s   = rdata.level > item_q.level;
    sts_o.div_busy = div_busy;
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  `PLT_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(MAX_POINTS))
  `PLT_ASSERT_ALWAYS(a_wr_in_range, !we || (k_q < CW'(MAX_POINTS)))
  `PLT_ASSERT_ALWAYS(a_mapped_zero, !out_valid_q || out_q.status == STAT_OK || out_q.mapped == '0)
  `PLT_ASSERT_NEXT(a_out_loaded, cmd_i.out_load, out_valid_q)

endmodule

>>> design/plt_ctrl.sv
// controller state machine sequencing map, insert, remove and clear
// depends on plt_pkg for command and status structs
module plt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  plt_pkg::plt_sts_t sts_i,
  output plt_pkg::plt_cmd_t cmd_o
);
  import plt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_MFIRST = 4'd2;
  localparam logic [3:0] S_MSCAN  = 4'd3;
  localparam logic [3:0] S_MMUL   = 4'd4;
  localparam logic [3:0] S_MDST   = 4'd5;
  localparam logic [3:0] S_MDIV   = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_REM    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    cmd_o           = '0;
    cmd_o.k_op      = K_HOLD;
    cmd_o.rd_off    = RD_K;
    cmd_o.wr_sel    = WR_NONE;
    cmd_o.cnt_op    = CNT_HOLD;
    cmd_o.res_sel   = RES_ZERO;
    cmd_o.stat      = STAT_OK;
    state_d         = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_MAP: begin
            if (sts_i.cnt_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.stat   = STAT_RANGE;
              state_d      = S_DONE;
            end else begin
              cmd_o.k_op = K_ZERO;
              state_d    = S_MFIRST;
            end
          end
          CMD_INSERT: begin
            if (sts_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.stat   = STAT_IGNORED;
              state_d      = S_DONE;
            end else begin
              cmd_o.k_op   = K_COUNT;
              cmd_o.rd_off = RD_KM1;
              state_d      = S_INS;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.pos_bad) begin
              cmd_o.finish = 1'b1;
              cmd_o.stat   = STAT_IGNORED;
              state_d      = S_DONE;
            end else begin
              cmd_o.k_op   = K_POS;
              cmd_o.rd_off = RD_KP1;
              state_d      = S_REM;
            end
          end
          CMD_CLEAR: begin
            cmd_o.cnt_op = CNT_CLR;
            cmd_o.finish = 1'b1;
            state_d      = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MFIRST, S_MSCAN: begin
        if (state_q == S_MSCAN && sts_i.x_gt_s) begin
          cmd_o.cur_ld = 1'b1;
          state_d      = S_MMUL;
        end else begin
          cmd_o.prev_ld = 1'b1;
          if (state_q == S_MFIRST && sts_i.s_lt_x) begin
            cmd_o.finish = 1'b1;
            cmd_o.stat   = STAT_RANGE;
            state_d      = S_DONE;
          end else if (sts_i.k_last) begin
            // end of table: only an exact hit on the last level maps
            cmd_o.finish  = 1'b1;
            cmd_o.res_sel = sts_i.s_eq_x ? RES_RDATA : RES_ZERO;
            cmd_o.stat    = sts_i.s_eq_x ? STAT_OK : STAT_RANGE;
            state_d       = S_DONE;
          end else begin
            cmd_o.k_op = K_INC;
            state_d    = S_MSCAN;
          end
        end
      end
      S_MMUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MDST;
      end
      S_MDST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MDIV;
      end
      S_MDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.finish  = 1'b1;
          cmd_o.res_sel = RES_INTERP;
          state_d       = S_DONE;
        end
      end
      S_INS: begin
        if (sts_i.k_zero || !sts_i.x_gt_s) begin
          cmd_o.wr_sel = WR_NEW;
          cmd_o.cnt_op = CNT_INC;
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.wr_sel = WR_RDATA;
          cmd_o.k_op   = K_DEC;
          cmd_o.rd_off = RD_KM1;
        end
      end
      S_REM: begin
        if (sts_i.k_last) begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.wr_sel = WR_RDATA;
          cmd_o.k_op   = K_INC;
          cmd_o.rd_off = RD_KP1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> design/piecewise_linear_transfer_table.sv
// Sorted breakpoint table with linear interpolation, one item at a time. A clear
// empties the table; an insert moves each point above its level up one place; a
// remove moves each point above its position down one place; a map scans the
// points of the point ram in order and, when it falls between two, multiplies and
// then divides with the 50-step divider. The next item is taken once the result is
// in the output register; one result per transfer, with status and point count.
module piecewise_linear_transfer_table #(
  parameter int unsigned MAX_POINTS = plt_pkg::PLT_MAX_POINTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  plt_pkg::plt_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output plt_pkg::plt_out_t out_o
);
  import plt_pkg::*;

  plt_cmd_t cmd;
  plt_sts_t sts;

  plt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  plt_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
